// ===== rtl/ps2md_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet decoder.
// Used by every module of the block; has no dependencies.
package ps2md_pkg;

  // Special bytes on the PS/2 link.
  localparam logic [7:0] BYTE_ACK       = 8'hFA;
  localparam logic [7:0] BYTE_SELF_TEST = 8'hAA;
  localparam logic [7:0] BYTE_ID_STD    = 8'h00;

  // Event kinds carried in tuser.
  localparam logic EVT_MOVE      = 1'b0;
  localparam logic EVT_RECONNECT = 1'b1;

  // Default depth of the queue between framing and decoding.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Width of the packed output data bus (25 payload bits rounded up to bytes).
  localparam int OUT_DATA_W = 32;

  // One framed event handed from the front to the back.
  typedef struct packed {
    logic       kind;   // EVT_MOVE or EVT_RECONNECT
    logic [7:0] head;   // first packet byte
    logic [7:0] b1;     // raw horizontal byte
    logic [7:0] b2;     // raw vertical byte
    logic [3:0] dz;     // wheel nibble, zero in standard mode
  } pkt_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/ps2md_front.sv =====
// Framing front end: accepts mouse bytes, tracks packet position and
// reconnect sequences, and pushes framed events. Depends on ps2md_pkg.
module ps2md_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wheel_mode,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  ps2md_pkg::q_status_t   q_status,
  output logic                   push,
  output ps2md_pkg::pkt_entry_t  push_entry
);
  import ps2md_pkg::*;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] previous_byte;
  logic [7:0] packet_bytes [3];
  logic       accepted;
  logic       reconnect;
  logic       store_byte;

  assign in_ready = !q_status.full;
  assign accepted = in_valid && in_ready;
  assign reconnect = (previous_byte == BYTE_SELF_TEST) && (in_byte == BYTE_ID_STD);

  always_comb begin
    byte_position_next = byte_position;
    store_byte         = 1'b0;
    push               = 1'b0;
    push_entry.kind    = EVT_MOVE;
    push_entry.head    = packet_bytes[0];
    push_entry.b1      = packet_bytes[1];
    push_entry.b2      = packet_bytes[2];
    push_entry.dz      = 4'd0;
    if (reconnect) begin
      byte_position_next = POS_FIRST;
      push               = accepted;
      push_entry.kind    = EVT_RECONNECT;
    end else if (in_byte == BYTE_ACK) begin
      byte_position_next = POS_FIRST;
    end else if (byte_position == POS_FIRST && !in_byte[3]) begin
      byte_position_next = POS_FIRST;
    end else if (byte_position == POS_FOURTH) begin
      // A fourth byte only completes a packet while wheel mode is on.
      byte_position_next = POS_FIRST;
      push               = accepted && wheel_mode;
      push_entry.dz      = in_byte[3:0];
    end else begin
      store_byte = 1'b1;
      if (byte_position == POS_THIRD && !wheel_mode) begin
        byte_position_next = POS_FIRST;
        push               = accepted;
        push_entry.b2      = in_byte;
      end else begin
        byte_position_next = byte_position + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
      previous_byte <= 8'd0;
    end else if (accepted) begin
      byte_position <= byte_position_next;
      if (!reconnect) begin
        previous_byte <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accepted && store_byte) begin
      packet_bytes[byte_position] <= in_byte;
    end
  end

endmodule

// ===== rtl/ps2md_queue.sv =====
// Short queue of framed events between the front end and the decoder.
// Depends on ps2md_pkg for the entry and status types.
module ps2md_queue #(
  parameter int DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ps2md_pkg::pkt_entry_t  push_entry,
  input  logic                   pop,
  output ps2md_pkg::pkt_entry_t  head_entry,
  output ps2md_pkg::q_status_t   status
);
  import ps2md_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pkt_entry_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_entry   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/ps2md_back.sv =====
// Decoder back end: pops framed events, drops overflowed packets or
// -256 deltas, drives the registered output. Depends on ps2md_pkg.
module ps2md_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ps2md_pkg::pkt_entry_t             head_entry,
  input  ps2md_pkg::q_status_t              q_status,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ps2md_pkg::OUT_DATA_W-1:0]  out_data,
  output logic                              out_kind
);
  import ps2md_pkg::*;

  logic       keep;
  logic       rx_min;
  logic       ry_min;
  logic [8:0] raw_y;
  logic [8:0] dx_next;
  logic [8:0] dy_next;
  logic [3:0] dz_next;
  logic       btn_l;
  logic       btn_r;
  logic       btn_m;
  logic [8:0] dx;
  logic [8:0] dy;
  logic [3:0] dz;

  // Pop whenever the output register is free or is being emptied.
  assign pop = !q_status.empty && (!out_valid || out_ready);

  assign rx_min = head_entry.head[4] && (head_entry.b1 == 8'd0);
  assign ry_min = head_entry.head[5] && (head_entry.b2 == 8'd0);
  assign raw_y  = {head_entry.head[5], head_entry.b2};

  always_comb begin
    keep    = 1'b1;
    dx_next = {head_entry.head[4], head_entry.b1};
    dy_next = 9'd0 - raw_y;
    dz_next = head_entry.dz;
    if (head_entry.kind == EVT_RECONNECT) begin
      dx_next = 9'd0;
      dy_next = 9'd0;
      dz_next = 4'd0;
    end else if (head_entry.head[6] || head_entry.head[7] || rx_min || ry_min) begin
      keep = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && keep) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && keep) begin
      out_kind <= head_entry.kind;
      btn_l    <= (head_entry.kind == EVT_MOVE) && head_entry.head[0];
      btn_r    <= (head_entry.kind == EVT_MOVE) && head_entry.head[1];
      btn_m    <= (head_entry.kind == EVT_MOVE) && head_entry.head[2];
      dx       <= dx_next;
      dy       <= dy_next;
      dz       <= dz_next;
    end
  end

  assign out_data = {7'd0, dz, dy, dx, btn_m, btn_r, btn_l};

endmodule

// ===== rtl/ps2_mouse_packet_decoder.sv =====
// Top level of the PS/2 mouse packet decoder: framing front end, event
// queue and decoding back end. Depends on ps2md_pkg and the ps2md_* modules.
//
// Usage: mouse bytes enter one item per cycle on the s_axis channel. The
// front end frames them into three-byte packets, or four-byte packets when
// wheel_mode is set through the cfg channel, and recognizes the reconnect
// sequence (self-test pass followed by ID zero). Acknowledge bytes and bad
// first bytes are dropped and restart framing. Each finished packet or
// reconnect goes into a short queue; the back end decodes it, drops packets
// flagged as overflowed or with a raw delta of -256, and presents one result
// item on m_axis, with tuser telling a movement packet from a reconnect.
// With an idle output, the packet completed by an accepted byte is written into
// the queue, and the back end then pops it into the output register, which
// raises m_axis_tvalid. Throughput: one byte per cycle while m_axis_tready
// is high, set by the framing step and the one-per-cycle queue pop.
// When the receiver stalls, the output register holds its item, the queue
// fills, and s_axis_tready drops once the queue is full; nothing is lost.
// Reset clears framing position, last byte, wheel_mode, the queue and the
// output valid. cfg_ready is always high; write wheel_mode only when idle.
module ps2_mouse_packet_decoder #(
  parameter int QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel; cfg_data is wheel_mode.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  // Input stream; tdata bits: [7:0] data_byte.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  // Output stream; tdata bits from the lowest: [0] left_button,
  // [1] right_button, [2] middle_button, [11:3] delta_x, [20:12] delta_y,
  // [24:21] delta_wheel, [31:25] zero.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ps2md_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser bits: [0] event_kind.
  output logic                              m_axis_tuser
);
  import ps2md_pkg::*;

  logic       wheel_mode;
  logic       push;
  logic       pop;
  pkt_entry_t push_entry;
  pkt_entry_t head_entry;
  q_status_t  q_status;

  // The mode register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode <= 1'b0;
    end else if (cfg_valid) begin
      wheel_mode <= cfg_data;
    end
  end

  ps2md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wheel_mode (wheel_mode),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  ps2md_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  ps2md_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_entry (head_entry),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_kind   (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // The queue can never report full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // A reconnect item carries all-zero data.
  a_reconnect_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == EVT_RECONNECT) |-> (m_axis_tdata == '0))
    else $error("reconnect item has nonzero data");

  // Movement items never carry a horizontal or vertical delta of -256.
  a_no_min_delta: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == EVT_MOVE) |->
      (m_axis_tdata[11:3] != 9'h100 && m_axis_tdata[20:12] != 9'h100))
    else $error("movement item with delta of -256");
`endif

endmodule
